### rtl/core/url_percent_encoder_core_defines.svh
// Assertion macros for the URL percent encoder RTL.
`ifndef URL_PERCENT_ENCODER_CORE_DEFINES_SVH
`define URL_PERCENT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, disabled during reset.
`define UPE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("upe assertion failed");

// Next-cycle implication, sampled on clock, disabled during reset.
`define UPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("upe assertion failed");

`endif

### rtl/core/upe_pkg.sv
// Types, character codes and helper functions for the URL percent encoder.
package upe_pkg;

   typedef enum logic [2:0] {
      PART_SCHEME       = 3'd0,
      PART_AFTER_SCHEME = 3'd1,
      PART_HOST         = 3'd2,
      PART_PATH         = 3'd3,
      PART_QUERY        = 3'd4,
      PART_FRAGMENT     = 3'd5
   } url_part_type;

   // Emitter phase within a percent escape.
   typedef enum logic [1:0] {
      PH_PCT = 2'd0,
      PH_HI  = 2'd1,
      PH_LO  = 2'd2
   } emit_phase_type;

   // Work queued between classifier and emitter.
   typedef struct packed {
      logic [7:0] data;
      logic       escape;
   } cmd_type;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;

   function automatic logic is_unreserved(logic [7:0] b);
      return b inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                       CH_DASH, CH_UNDER, CH_DOT, CH_TILDE};
   endfunction

   // Uppercase hex digit for one nibble.
   function automatic logic [7:0] hex_digit(logic [3:0] n);
      logic [7:0] ext;
      ext = {4'h0, n};
      if (n < 4'd10) begin
         return CH_ZERO + ext;
      end
      return CH_UP_A - 8'd10 + ext;
   endfunction

endpackage

### rtl/core/upe_front.sv
// Front end: accepts input bytes, tracks the URL part and decides escaping.
module upe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_start_of_url,
   output logic             push_valid,
   input  logic             push_ready,
   output upe_pkg::cmd_type push_cmd
);

   upe_pkg::url_part_type part_ff;
   upe_pkg::url_part_type part_in;
   upe_pkg::url_part_type cur_part;
   upe_pkg::url_part_type next_part;
   logic                  escape;
   logic                  unres;
   logic                  accept;

   assign req_stall  = !push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid;
   assign unres      = upe_pkg::is_unreserved(req_in_byte);

   always_comb begin
      cur_part  = req_start_of_url ? upe_pkg::PART_SCHEME : part_ff;
      next_part = cur_part;
      escape    = 1'b0;
      case (cur_part)
         upe_pkg::PART_SCHEME, upe_pkg::PART_AFTER_SCHEME, upe_pkg::PART_HOST: begin
            if (req_in_byte == upe_pkg::CH_SLASH) begin
               next_part = upe_pkg::url_part_type'(cur_part + 3'd1);
            end
         end
         upe_pkg::PART_PATH: begin
            if (req_in_byte == upe_pkg::CH_QUEST) begin
               next_part = upe_pkg::PART_QUERY;
            end else begin
               escape = !(unres || req_in_byte == upe_pkg::CH_SLASH);
            end
         end
         upe_pkg::PART_QUERY: begin
            if (req_in_byte == upe_pkg::CH_HASH) begin
               next_part = upe_pkg::PART_FRAGMENT;
            end else begin
               escape = !(unres || req_in_byte == upe_pkg::CH_AMP ||
                          req_in_byte == upe_pkg::CH_EQUAL);
            end
         end
         default: begin
            escape = !unres;
         end
      endcase
   end

   assign push_cmd.data   = req_in_byte;
   assign push_cmd.escape = escape;
   assign part_in         = accept ? next_part : part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= upe_pkg::PART_SCHEME;
      end else begin
         part_ff <= part_in;
      end
   end

endmodule

### rtl/core/upe_queue.sv
// Small FIFO of classified bytes between front and back end.
module upe_queue #(
   parameter int QueueDepth = upe_pkg::QUEUE_DEPTH  // at least 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  upe_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output upe_pkg::cmd_type pop_cmd
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

   upe_pkg::cmd_type mem [QueueDepth];
   upe_pkg::cmd_type head_ff;
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // head follows the next read slot; a write into that slot passes straight through
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
      if (push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= push_cmd;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

endmodule

### rtl/core/upe_back.sv
// Back end: emits a byte as-is or as a three-byte percent escape.
`include "url_percent_encoder_core_defines.svh"

module upe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  upe_pkg::cmd_type pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last
);

   upe_pkg::cmd_type       cmd_ff, cmd_in;
   logic                   busy_ff, busy_in;
   upe_pkg::emit_phase_type phase_ff, phase_in;
   logic                   fire, done;

   assign rsp_valid    = busy_ff;
   assign rsp_run_last = !cmd_ff.escape || (phase_ff == upe_pkg::PH_LO);
   assign fire         = busy_ff && !rsp_stall;
   assign done         = fire && rsp_run_last;
   assign pop_ready    = !busy_ff || done;

   always_comb begin
      case (phase_ff)
         upe_pkg::PH_PCT: rsp_out_byte = upe_pkg::CH_PERCENT;
         upe_pkg::PH_HI:  rsp_out_byte = upe_pkg::hex_digit(cmd_ff.data[7:4]);
         default:         rsp_out_byte = upe_pkg::hex_digit(cmd_ff.data[3:0]);
      endcase
      if (!cmd_ff.escape) begin
         rsp_out_byte = cmd_ff.data;
      end
   end

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      if (pop_valid && pop_ready) begin
         cmd_in   = pop_cmd;
         phase_in = upe_pkg::PH_PCT;
         busy_in  = 1'b1;
      end else if (done) begin
         busy_in  = 1'b0;
      end else if (fire) begin
         phase_in = upe_pkg::emit_phase_type'(phase_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= upe_pkg::PH_PCT;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   `UPE_ASSERT_IMPLY(a_plain_single_phase, busy_ff && !cmd_ff.escape, phase_ff == upe_pkg::PH_PCT)
   `UPE_ASSERT_IMPLY(a_phase_in_range, busy_ff, phase_ff != 2'd3)
   `UPE_ASSERT_NEXT(a_escape_advances, fire && !rsp_run_last,
      busy_ff && phase_ff == $past(phase_ff) + 2'd1)
   `UPE_ASSERT_NEXT(a_no_load_mid_escape, busy_ff && !rsp_run_last,
      $stable(cmd_ff))

endmodule

### rtl/core/url_percent_encoder_core.sv
// URL percent encoder: one input byte in, one or three encoded bytes out.
//
// Input channel (req_): one raw URL byte per transaction; req_start_of_url
// restarts the part tracker at the scheme before that byte is classified.
// Output channel (rsp_): one encoded byte per transaction; rsp_run_last marks
// the final byte produced for an input byte.
// Both channels: a transaction completes on a clock edge with valid high and
// stall low.
// Path: with the pipe empty, an input byte is classified into the queue, then
// loaded into the emitter, whose register drives the first output byte.
// Throughput: the emitter sends one byte per cycle while rsp_stall is low, a
// plain byte as one output byte and an escaped byte as three; the queue (two
// entries by default) lets new bytes arrive while an escape is still going out.
// Reset (synchronous, active high) empties the queue and the emitter and
// returns the tracker to the scheme part.
// When rsp_stall is high the current output byte holds; the queue fills and
// req_stall rises once it is full.
module url_percent_encoder_core #(
   parameter int QueueDepth = upe_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_of_url,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic             push_valid, push_ready;
   upe_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   upe_pkg::cmd_type pop_cmd;

   upe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_start_of_url (req_start_of_url),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_cmd         (push_cmd)
   );

   upe_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   upe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_cmd      (pop_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule
